### sv/krtt_pkg.sv
// Shared types and constants for the keyed repeating timer table.
// Used by krtt_ctrl, krtt_dp and the top level; depends on nothing.
`default_nettype none

package krtt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CMD_W = 2;
    localparam int MOD_W = 8;
    localparam int IDX_W = 32;
    localparam int PER_W = 31;
    localparam int REP_W = 8;
    localparam int NREP_W = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // one slot as held in the slot memory
    typedef struct packed {
        logic [MOD_W-1:0] module_id;
        logic [IDX_W-1:0] key_index;
        logic [PER_W-1:0] period;
        logic [REP_W-1:0] repeats_left;
        logic [PER_W-1:0] remaining;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic set_hit;
        logic set_new;
        logic del_hit;
        logic step;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hit;
        logic             used_zero;
        logic             full;
        logic             at_last;
        logic             pend_v;
        logic             out_free;
        logic             block;
    } t_sts;

endpackage

`default_nettype wire

### sv/krtt_dp.sv
// Datapath of the timer table: slot memory, armed bits, captured command,
// pending and output result registers. Depends on krtt_pkg.
`default_nettype none

module krtt_dp #(
    parameter int SLOTS = krtt_pkg::SLOTS_DEF,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int UW    = $clog2(SLOTS + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire krtt_pkg::t_cmd          i_cmd,
    input  wire [AW-1:0]                 i_ptr,
    input  wire [AW-1:0]                 i_rd_addr,
    output krtt_pkg::t_sts               o_sts,
    input  wire [krtt_pkg::CMD_W-1:0]    i_command,
    input  wire [krtt_pkg::MOD_W-1:0]    i_module_id,
    input  wire [krtt_pkg::IDX_W-1:0]    i_timer_index,
    input  wire [krtt_pkg::PER_W-1:0]    i_period_ms,
    input  wire [krtt_pkg::REP_W-1:0]    i_repeat_count,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [krtt_pkg::MOD_W-1:0]   o_expired_module,
    output logic [krtt_pkg::IDX_W-1:0]   o_expired_index,
    output logic                         o_last
);

    krtt_pkg::t_entry r_mem [SLOTS];
    krtt_pkg::t_entry r_rd_q;

    logic [krtt_pkg::CMD_W-1:0]  r_cmd;
    logic [krtt_pkg::MOD_W-1:0]  r_mod;
    logic [krtt_pkg::IDX_W-1:0]  r_idx;
    logic [krtt_pkg::PER_W-1:0]  r_per;
    logic [krtt_pkg::REP_W-1:0]  r_rep;

    logic [SLOTS-1:0]            r_armed;
    logic [UW-1:0]               r_used;
    logic [krtt_pkg::NREP_W-1:0] r_nrep;

    logic                        r_pend_v;
    logic [krtt_pkg::MOD_W-1:0]  r_pend_mod;
    logic [krtt_pkg::IDX_W-1:0]  r_pend_idx;

    logic                        r_out_v;
    logic [krtt_pkg::MOD_W-1:0]  r_out_mod;
    logic [krtt_pkg::IDX_W-1:0]  r_out_idx;
    logic                        r_out_last;

    logic                        cur_armed;
    logic                        expire;
    logic                        report_ok;
    logic                        report;
    logic                        out_free;
    logic [krtt_pkg::PER_W-1:0]  rem_dec;
    krtt_pkg::t_entry            tick_entry;
    krtt_pkg::t_entry            load_entry;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    krtt_pkg::t_entry            wr_data;

    always_comb begin
        cur_armed = r_armed[i_ptr];
        rem_dec   = (r_rd_q.remaining == '0) ? r_rd_q.remaining
                                             : r_rd_q.remaining - 1'b1;
        expire    = cur_armed && (rem_dec == '0);
        report_ok = r_nrep < krtt_pkg::NREP_W'(krtt_pkg::MAX_RESULTS);
        report    = i_cmd.step && expire && report_ok;
        out_free  = !r_out_v || !i_out_stall;

        tick_entry = r_rd_q;
        if (expire) begin
            tick_entry.remaining = r_rd_q.period;
            if (r_rd_q.repeats_left > krtt_pkg::REP_W'(1)) begin
                tick_entry.repeats_left = r_rd_q.repeats_left - 1'b1;
            end
        end else begin
            tick_entry.remaining = rem_dec;
        end

        load_entry.module_id    = r_mod;
        load_entry.key_index    = r_idx;
        load_entry.period       = r_per;
        load_entry.repeats_left = r_rep;
        load_entry.remaining    = r_per;

        wr_en   = i_cmd.set_hit || i_cmd.set_new || (i_cmd.step && cur_armed);
        wr_addr = i_cmd.set_new ? r_used[AW-1:0] : i_ptr;
        wr_data = i_cmd.step ? tick_entry : load_entry;

        o_sts.cmd       = r_cmd;
        o_sts.hit       = (r_rd_q.module_id == r_mod) && (r_rd_q.key_index == r_idx);
        o_sts.used_zero = (r_used == '0);
        o_sts.full      = (r_used == UW'(SLOTS));
        o_sts.at_last   = ((UW+1)'(i_ptr) + (UW+1)'(1)) == (UW+1)'(r_used);
        o_sts.pend_v    = r_pend_v;
        o_sts.out_free  = out_free;
        o_sts.block     = expire && report_ok && r_pend_v && !out_free;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_mod <= i_module_id;
            r_idx <= i_timer_index;
            r_per <= i_period_ms;
            r_rep <= i_repeat_count;
        end
        if (report) begin
            r_pend_mod <= r_rd_q.module_id;
            r_pend_idx <= r_rd_q.key_index;
        end
        if ((report && r_pend_v) || i_cmd.flush) begin
            r_out_mod  <= r_pend_mod;
            r_out_idx  <= r_pend_idx;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= '0;
            r_used   <= '0;
            r_nrep   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.set_hit) begin
                r_armed[i_ptr] <= (r_per != '0);
            end
            if (i_cmd.set_new) begin
                r_armed[r_used[AW-1:0]] <= (r_per != '0);
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.del_hit) begin
                r_armed[i_ptr] <= 1'b0;
            end
            // a count of one fires once, then disarm the slot
            if (i_cmd.step && expire && (r_rd_q.repeats_left == krtt_pkg::REP_W'(1))) begin
                r_armed[i_ptr] <= 1'b0;
            end

            if (i_cmd.capture) begin
                r_nrep <= '0;
            end else if (report) begin
                r_nrep <= r_nrep + 1'b1;
            end

            if (report) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end

            if ((report && r_pend_v) || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_expired_module = r_out_mod;
    assign o_expired_index  = r_out_idx;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

### sv/krtt_ctrl.sv
// Controller of the timer table: walks the slots for each command beat and
// steers the datapath. Depends on krtt_pkg.
`default_nettype none

module krtt_ctrl #(
    parameter int SLOTS = krtt_pkg::SLOTS_DEF,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire krtt_pkg::t_sts i_sts,
    output krtt_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_ptr,
    output logic [AW-1:0]   o_rd_addr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic          is_tick;
    logic          is_set;
    logic          is_del;

    always_comb begin
        is_tick = (i_sts.cmd == krtt_pkg::CMD_TICK);
        is_set  = (i_sts.cmd == krtt_pkg::CMD_SET);
        is_del  = (i_sts.cmd == krtt_pkg::CMD_DELETE);

        n_state = r_state;
        n_ptr   = r_ptr;
        o_cmd   = '0;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_ptr = '0;
                if (!(is_tick || is_set || is_del)) begin
                    n_state = S_IDLE;
                end else if (i_sts.used_zero) begin
                    o_cmd.set_new = is_set;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (is_tick) begin
                    // hold on this slot while the older result cannot move out
                    if (!i_sts.block) begin
                        o_cmd.step = 1'b1;
                        if (i_sts.at_last) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_ptr = r_ptr + 1'b1;
                            o_cmd.rd_en = 1'b1;
                        end
                    end
                end else if (i_sts.hit) begin
                    o_cmd.set_hit = is_set;
                    o_cmd.del_hit = is_del;
                    n_state = S_IDLE;
                end else if (i_sts.at_last) begin
                    o_cmd.set_new = is_set && !i_sts.full;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_rd_addr = n_ptr;
        o_ptr     = r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

endmodule

`default_nettype wire

### sv/keyed_repeating_timer_table.sv
// Keyed repeating timer table: up to SLOTS timers keyed by module id and
// timer index, counted down by tick beats.
// Input channel: one beat is a command (set, delete, tick) with key, period
// and repeat count; o_in_stall is high while a beat is being worked on.
// Output channel: one beat per expiry on a tick, in slot order; o_last marks
// the final expiry of that tick, and at most 16 are reported per tick.
// A set or delete compares the slots in use (at most SLOTS) in order until
// the key matches; a set that adds a slot finishes with the last compare.
// A tick walks every slot in use (none on an empty table), one slot per
// cycle through the single read port of the slot memory while the walk is
// not paused, then hands out the held final expiry once the output is free.
// An idle block takes an offered beat; a new beat waits until the last one ends.
// The output register holds a result while the receiver stalls; the walk
// pauses on a slot only when a second expiry is waiting to move out.
// Synchronous reset empties the table and disarms every slot; slot memory
// contents are not cleared, since only written slots are ever read.
// Depends on krtt_pkg, krtt_ctrl and krtt_dp.
`default_nettype none

module keyed_repeating_timer_table #(
    parameter int SLOTS = krtt_pkg::SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [krtt_pkg::CMD_W-1:0]    i_command,
    input  wire [krtt_pkg::MOD_W-1:0]    i_module_id,
    input  wire [krtt_pkg::IDX_W-1:0]    i_timer_index,
    input  wire [krtt_pkg::PER_W-1:0]    i_period_ms,
    input  wire [krtt_pkg::REP_W-1:0]    i_repeat_count,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [krtt_pkg::MOD_W-1:0]   o_expired_module,
    output logic [krtt_pkg::IDX_W-1:0]   o_expired_index,
    output logic                         o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);

    krtt_pkg::t_cmd cmd;
    krtt_pkg::t_sts sts;
    logic [AW-1:0]  ptr;
    logic [AW-1:0]  rd_addr;

    krtt_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ptr      (ptr),
        .o_rd_addr  (rd_addr)
    );

    krtt_dp #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .UW    (UW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_ptr            (ptr),
        .i_rd_addr        (rd_addr),
        .o_sts            (sts),
        .i_command        (i_command),
        .i_module_id      (i_module_id),
        .i_timer_index    (i_timer_index),
        .i_period_ms      (i_period_ms),
        .i_repeat_count   (i_repeat_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_expired_module (o_expired_module),
        .o_expired_index  (o_expired_index),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking bench for keyed_repeating_timer_table: a directed table of beats,
// then random set, delete, tick and unused-command beats checked against a timer-table model.
// Depends on krtt_pkg and the keyed_repeating_timer_table RTL.

module tb;
    import krtt_pkg::*;

    localparam int TABLE_SLOTS      = SLOTS_DEF;
    localparam int POOL_KEYS        = 24;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 4 * TABLE_SLOTS + 16;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [MOD_W-1:0] mod;
        logic [IDX_W-1:0] idx;
        logic             last;
    } expiry_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MOD_W-1:0] mod;
        logic [IDX_W-1:0] idx;
        logic [PER_W-1:0] per;
        logic [REP_W-1:0] rep;
        int               want_n;
        logic [MOD_W-1:0] want_mod;
        logic [IDX_W-1:0] want_idx;
    } stim_row_t;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_stall;
    logic [CMD_W-1:0] i_command      = '0;
    logic [MOD_W-1:0] i_module_id    = '0;
    logic [IDX_W-1:0] i_timer_index  = '0;
    logic [PER_W-1:0] i_period_ms    = '0;
    logic [REP_W-1:0] i_repeat_count = '0;
    logic             o_out_valid;
    logic             i_out_stall    = 1'b0;
    logic [MOD_W-1:0] o_expired_module;
    logic [IDX_W-1:0] o_expired_index;
    logic             o_last;

    keyed_repeating_timer_table #(.SLOTS(TABLE_SLOTS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_module_id      (i_module_id),
        .i_timer_index    (i_timer_index),
        .i_period_ms      (i_period_ms),
        .i_repeat_count   (i_repeat_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_expired_module (o_expired_module),
        .o_expired_index  (o_expired_index),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timer table model
    int               slots_taken = 0;
    logic [MOD_W-1:0] key_mod     [TABLE_SLOTS];
    logic [IDX_W-1:0] key_idx     [TABLE_SLOTS];
    logic [PER_W-1:0] load_period [TABLE_SLOTS];
    logic [REP_W-1:0] reps_left   [TABLE_SLOTS];
    logic [PER_W-1:0] count_ms    [TABLE_SLOTS];
    bit               armed       [TABLE_SLOTS];

    expiry_t          expiry_q [$];
    expiry_t          newest_expiry;
    stim_row_t        script_q [$];
    logic [MOD_W-1:0] pool_mod [POOL_KEYS];
    logic [IDX_W-1:0] pool_idx [POOL_KEYS];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    function automatic int find_key(input logic [MOD_W-1:0] m, input logic [IDX_W-1:0] k);
        int hit;
        hit = -1;
        for (int s = 0; s < slots_taken; s++)
            if (hit < 0 && key_mod[s] == m && key_idx[s] == k) hit = s;
        return hit;
    endfunction

    // apply one beat to the model; queue the expiries it causes and return their count
    function automatic int timer_table_step(input logic [CMD_W-1:0] cmd,
                                            input logic [MOD_W-1:0] m,
                                            input logic [IDX_W-1:0] k,
                                            input logic [PER_W-1:0] per,
                                            input logic [REP_W-1:0] rep);
        int      s;
        int      n;
        bit      have_held;
        expiry_t held;
        n = 0;
        have_held = 1'b0;
        held = '0;
        case (cmd)
            CMD_SET: begin
                s = find_key(m, k);
                if (s < 0 && slots_taken < TABLE_SLOTS) begin
                    s = slots_taken;
                    key_mod[s] = m;
                    key_idx[s] = k;
                    slots_taken++;
                end
                if (s >= 0) begin
                    load_period[s] = per;
                    reps_left[s]   = rep;
                    count_ms[s]    = per;
                    armed[s]       = (per != '0);
                end
            end
            CMD_DELETE: begin
                s = find_key(m, k);
                if (s >= 0) armed[s] = 1'b0;
            end
            CMD_TICK: begin
                for (s = 0; s < slots_taken; s++) begin
                    if (armed[s]) begin
                        if (count_ms[s] != '0) count_ms[s] = count_ms[s] - 1'b1;
                        if (count_ms[s] == '0) begin
                            // hold back the newest expiry so the final one gets last set
                            if (n < MAX_RESULTS) begin
                                if (have_held) expiry_q.push_back(held);
                                held.mod  = key_mod[s];
                                held.idx  = key_idx[s];
                                held.last = 1'b0;
                                have_held = 1'b1;
                                n++;
                            end
                            if (reps_left[s] > 8'd1) begin
                                reps_left[s] = reps_left[s] - 1'b1;
                                count_ms[s]  = load_period[s];
                            end else if (reps_left[s] == '0) begin
                                count_ms[s] = load_period[s];
                            end else begin
                                armed[s] = 1'b0;
                            end
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expiry_q.push_back(held);
                    newest_expiry = held;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // offer one beat after a random idle gap, hold it until taken, then predict
    task automatic offer_beat(input logic [CMD_W-1:0] cmd, input logic [MOD_W-1:0] m,
                              input logic [IDX_W-1:0] k, input logic [PER_W-1:0] per,
                              input logic [REP_W-1:0] rep, output int n);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_module_id    <= m;
        i_timer_index  <= k;
        i_period_ms    <= per;
        i_repeat_count <= rep;
        do @(posedge i_clk); while (o_in_stall);
        n = timer_table_step(cmd, m, k, per, rep);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [MOD_W-1:0] m,
                           input logic [IDX_W-1:0] k, input logic [PER_W-1:0] per,
                           input logic [REP_W-1:0] rep, input int want_n,
                           input logic [MOD_W-1:0] want_mod, input logic [IDX_W-1:0] want_idx);
        stim_row_t row;
        row.cmd      = cmd;
        row.mod      = m;
        row.idx      = k;
        row.per      = per;
        row.rep      = rep;
        row.want_n   = want_n;
        row.want_mod = want_mod;
        row.want_idx = want_idx;
        script_q.push_back(row);
    endtask

    task automatic random_beat();
        logic [31:0]      r32;
        int               pick;
        int               n;
        logic [CMD_W-1:0] cmd;
        logic [MOD_W-1:0] m;
        logic [IDX_W-1:0] k;
        logic [PER_W-1:0] per;
        logic [REP_W-1:0] rep;
        pick = $urandom_range(POOL_KEYS - 1);
        m = pool_mod[pick];
        k = pool_idx[pick];
        if ($urandom_range(15) == 0) begin
            r32 = $urandom;
            m = r32[MOD_W-1:0];
            k = $urandom;
        end
        r32 = $urandom_range(6);
        per = r32[PER_W-1:0];
        if ($urandom_range(9) == 0) begin
            r32 = $urandom;
            per = r32[PER_W-1:0];
        end
        r32 = $urandom_range(4);
        rep = r32[REP_W-1:0];
        if ($urandom_range(7) == 0) begin
            r32 = $urandom;
            rep = r32[REP_W-1:0];
        end
        pick = $urandom_range(99);
        if (pick < 50) cmd = CMD_TICK;
        else if (pick < 80) cmd = CMD_SET;
        else if (pick < 96) cmd = CMD_DELETE;
        else cmd = CMD_SPARE;
        offer_beat(cmd, m, k, per, rep, n);
    endtask

    // rearm every slot in use with a one-tick period, then tick them all at once
    task automatic fire_all_slots(input logic [REP_W-1:0] rep);
        int n;
        for (int s = 0; s < slots_taken; s++)
            offer_beat(CMD_SET, key_mod[s], key_idx[s], 31'd1, rep, n);
        offer_beat(CMD_TICK, '0, '0, '0, '0, n);
    endtask

    // receiver: random stalls, or a long hold-off counted here when requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expiry_q.size() == 0) begin
                report_mismatch($sformatf("expiry %02h/%08h with none pending",
                                          o_expired_module, o_expired_index));
            end else begin
                newest_check(expiry_q.pop_front());
            end
        end
    end

    task automatic newest_check(input expiry_t want);
        if (o_expired_module !== want.mod || o_expired_index !== want.idx
                || o_last !== want.last)
            report_mismatch($sformatf("expiry %02h/%08h last %b, wanted %02h/%08h last %b",
                                      o_expired_module, o_expired_index, o_last,
                                      want.mod, want.idx, want.last));
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        stim_row_t   step;
        int          n;
        logic [31:0] r32;

        // empty table, extremes of key, period and count, every command, special cases
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_SET,    8'h00, 32'h0000_0000, 31'd1, 8'd1, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 1, 8'h00, 32'h0000_0000);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_SET,    8'hFF, 32'hFFFF_FFFF, 31'd2, 8'd0, 0, '0, '0);
        add_row(CMD_SET,    8'hA5, 32'h5A5A_5A5A, 31'd0, 8'd3, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 1, 8'hFF, 32'hFFFF_FFFF);
        add_row(CMD_DELETE, 8'hFF, 32'hFFFF_FFFF, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_DELETE, 8'h12, 32'h0000_0034, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_DELETE, 8'hA5, 32'h5A5A_5A5A, 31'd0, 8'd0, 0, '0, '0);
        add_row(CMD_SPARE,  8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 0, '0, '0);
        add_row(CMD_TICK,   8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 0, '0, '0);
        add_row(CMD_SET,    8'h00, 32'h0000_0000, 31'd1, 8'd2, 0, '0, '0);
        add_row(CMD_SET,    8'h5A, 32'hA5A5_A5A5, 31'd1, 8'd0, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, -1, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, -1, '0, '0);
        add_row(CMD_SET,    8'h80, 32'h8000_0000, 31'h7FFF_FFFF, 8'hFF, 0, '0, '0);
        add_row(CMD_SET,    8'h01, 32'h0000_0001, 31'd3, 8'd255, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, -1, '0, '0);
        add_row(CMD_SET,    8'hFF, 32'hFFFF_FFFF, 31'd1, 8'd1, 0, '0, '0);
        add_row(CMD_TICK,   8'h00, 32'h0000_0000, 31'd0, 8'd0, -1, '0, '0);

        for (int p = 0; p < POOL_KEYS; p++) begin
            r32 = $urandom;
            pool_mod[p] = r32[MOD_W-1:0];
            pool_idx[p] = $urandom;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < script_q.size(); r++) begin
            step = script_q[r];
            offer_beat(step.cmd, step.mod, step.idx, step.per, step.rep, n);
            if (step.want_n >= 0 && n != step.want_n)
                report_mismatch($sformatf("row %0d: %0d expiries predicted, %0d listed",
                                          r, n, step.want_n));
            else if (step.want_n == 1 && (newest_expiry.mod != step.want_mod
                                          || newest_expiry.idx != step.want_idx))
                report_mismatch($sformatf("row %0d: predicted %02h/%08h, listed %02h/%08h",
                                          r, newest_expiry.mod, newest_expiry.idx,
                                          step.want_mod, step.want_idx));
        end

        // fill the table from the key pool; sets past the last slot are dropped
        for (int p = 0; p < POOL_KEYS; p++) begin
            r32 = $urandom_range(1, 6);
            offer_beat(CMD_SET, pool_mod[p], pool_idx[p], r32[PER_W-1:0], 8'd0, n);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                1: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                2: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) random_beat();
            if (phase == 3) begin
                // back up the output with forever-repeating expiries, keep ticking
                fire_all_slots(8'd0);
                hold_requests++;
                for (int i = 0; i < 25; i++) offer_beat(CMD_TICK, '0, '0, '0, '0, n);
            end else begin
                r32 = $urandom_range(2);
                fire_all_slots(r32[REP_W-1:0]);
            end
            for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) random_beat();
        end

        i_in_valid <= 1'b0;
        while (expiry_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
